// ----- sv/rmq_pkg.sv -----
`default_nettype none
package rmq_pkg;

	localparam int FRAC_BITS_DEF  = 14;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int LANES          = 4;

	typedef logic [1:0] branch_t;

	localparam branch_t BR_TRACE = 2'd0;
	localparam branch_t BR_X     = 2'd1;
	localparam branch_t BR_Y     = 2'd2;
	localparam branch_t BR_Z     = 2'd3;

endpackage
`default_nettype wire

// ----- sv/rotation_matrix_to_quaternion_core.sv -----
// Pipeline: one decode stage, one square-root cell per root bit, one
// rounding-offset stage, one divider cell per quotient bit, and the output
// register.
// Throughput: one word per cycle; the whole chain stalls only while out_valid is high and out_ready low.
// Reset (arst_n, asynchronous): clears the valid chain and the output valid.
`default_nettype none
module rotation_matrix_to_quaternion_core
	import rmq_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [DATA_WIDTH-1:0]  m00,
	input  wire logic signed [DATA_WIDTH-1:0]  m01,
	input  wire logic signed [DATA_WIDTH-1:0]  m02,
	input  wire logic signed [DATA_WIDTH-1:0]  m10,
	input  wire logic signed [DATA_WIDTH-1:0]  m11,
	input  wire logic signed [DATA_WIDTH-1:0]  m12,
	input  wire logic signed [DATA_WIDTH-1:0]  m20,
	input  wire logic signed [DATA_WIDTH-1:0]  m21,
	input  wire logic signed [DATA_WIDTH-1:0]  m22,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [DATA_WIDTH-1:0]       quat_w,
	output logic signed [DATA_WIDTH-1:0]       quat_x,
	output logic signed [DATA_WIDTH-1:0]       quat_y,
	output logic signed [DATA_WIDTH-1:0]       quat_z,
	output logic [1:0]                         branch_taken,
	output logic                               degenerate
);

	localparam int DW    = DATA_WIDTH;
	localparam int F     = FRAC_BITS;
	localparam int AW    = ((DW > F + 1) ? DW : F + 1) + 3;
	localparam int NW    = AW - 1 + F - 2;
	localparam int NWE   = NW + (NW % 2);
	localparam int RW    = NWE / 2;
	localparam int MW    = DW + 1;
	localparam int NUMW  = MW + F - 2;
	localparam int NMW   = ((NUMW > RW) ? NUMW : RW) + 1;
	localparam int SQ_SW = 3 + LANES + LANES * MW;
	localparam int DV_SW = 3 + LANES;
	localparam int NV    = 2 + RW + NMW;

	localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MIN_NEG = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] ONE_SAT = (F >= DW - 1) ? MAX_POS : DW'(64'd1 << F);

	logic            adv;
	logic [NV-1:0]   vld_q;
	logic            out_valid_q;

	branch_t                 branch_s1;
	logic                    degen_s1;
	logic [AW-2:0]           arg_s1;
	logic [LANES-1:0]        neg_s1;
	logic [LANES-1:0][MW-1:0] mag_s1;

	logic [NWE-1:0]   sq_rad  [0:RW];
	logic [RW:0]      sq_rem  [0:RW];
	logic [RW-1:0]    sq_root [0:RW];
	logic [SQ_SW-1:0] sq_side [0:RW];

	branch_t                  sq_br;
	logic                     sq_dg;
	logic [LANES-1:0]         sq_ng;
	logic [LANES-1:0][MW-1:0] sq_mag;

	logic [RW-1:0]               h_s2;
	logic [LANES-1:0][NMW-1:0]   dvd_s2;
	logic [DV_SW-1:0]            side_s2;

	logic [RW-1:0]               dv_h    [0:NMW];
	logic [LANES-1:0][NMW-1:0]   dv_dvd  [0:NMW];
	logic [LANES-1:0][RW-1:0]    dv_rem  [0:NMW];
	logic [LANES-1:0][NMW-1:0]   dv_quo  [0:NMW];
	logic [DV_SW-1:0]            dv_side [0:NMW];

	branch_t          fin_br;
	logic             fin_dg;
	logic [LANES-1:0] fin_ng;
	logic [DW-1:0]    res [LANES];

	logic [DW-1:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;
	branch_t       branch_q;
	logic          degen_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[NV-2:0], in_valid};
			out_valid_q <= vld_q[NV-1];
		end
	end

	rmq_front #(
		.DATA_WIDTH(DW),
		.FRAC_BITS (F),
		.AW        (AW)
	) u_front (
		.clk      (clk),
		.en       (adv),
		.m00      (m00),
		.m01      (m01),
		.m02      (m02),
		.m10      (m10),
		.m11      (m11),
		.m12      (m12),
		.m20      (m20),
		.m21      (m21),
		.m22      (m22),
		.branch_s1(branch_s1),
		.degen_s1 (degen_s1),
		.arg_s1   (arg_s1),
		.neg_s1   (neg_s1),
		.mag_s1   (mag_s1)
	);

	assign sq_rad[0]  = NWE'(arg_s1) << (F - 2);
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = {branch_s1, degen_s1, neg_s1, mag_s1};

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		rmq_sqrt_cell #(
			.RW(RW),
			.SW(SQ_SW)
		) u_cell (
			.clk   (clk),
			.en    (adv),
			.rad_i (sq_rad[k]),
			.rem_i (sq_rem[k]),
			.root_i(sq_root[k]),
			.side_i(sq_side[k]),
			.rad_o (sq_rad[k+1]),
			.rem_o (sq_rem[k+1]),
			.root_o(sq_root[k+1]),
			.side_o(sq_side[k+1])
		);
	end

	assign {sq_br, sq_dg, sq_ng, sq_mag} = sq_side[RW];

	// add h/2 so the truncating divide rounds to nearest
	always_ff @(posedge clk) begin
		if (adv) begin
			h_s2    <= sq_root[RW];
			side_s2 <= {sq_br, sq_dg, sq_ng};
			for (int l = 0; l < LANES; l++) begin
				dvd_s2[l] <= (NMW'(sq_mag[l]) << (F - 2)) + NMW'(sq_root[RW] >> 1);
			end
		end
	end

	assign dv_h[0]    = h_s2;
	assign dv_dvd[0]  = dvd_s2;
	assign dv_rem[0]  = '0;
	assign dv_quo[0]  = '0;
	assign dv_side[0] = side_s2;

	for (genvar k = 0; k < NMW; k++) begin : g_div
		rmq_div_cell #(
			.RW (RW),
			.NMW(NMW),
			.SW (DV_SW)
		) u_cell (
			.clk   (clk),
			.en    (adv),
			.h_i   (dv_h[k]),
			.dvd_i (dv_dvd[k]),
			.rem_i (dv_rem[k]),
			.quo_i (dv_quo[k]),
			.side_i(dv_side[k]),
			.h_o   (dv_h[k+1]),
			.dvd_o (dv_dvd[k+1]),
			.rem_o (dv_rem[k+1]),
			.quo_o (dv_quo[k+1]),
			.side_o(dv_side[k+1])
		);
	end

	assign {fin_br, fin_dg, fin_ng} = dv_side[NMW];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (fin_dg) begin
				res[l] = (l == 0) ? ONE_SAT : '0;
			end else if (fin_br == 2'(l)) begin
				res[l] = (dv_h[NMW] > MAX_POS) ? MAX_POS : DW'(dv_h[NMW]);
			end else if (fin_ng[l]) begin
				res[l] = (dv_quo[NMW][l] > {1'b0, MIN_NEG}) ? MIN_NEG
					: DW'(0 - dv_quo[NMW][l][DW-1:0]);
			end else begin
				res[l] = (dv_quo[NMW][l] > MAX_POS) ? MAX_POS : dv_quo[NMW][l][DW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quat_w_q <= res[0];
			quat_x_q <= res[1];
			quat_y_q <= res[2];
			quat_z_q <= res[3];
			branch_q <= fin_br;
			degen_q  <= fin_dg;
		end
	end

	assign out_valid    = out_valid_q;
	assign quat_w       = quat_w_q;
	assign quat_x       = quat_x_q;
	assign quat_y       = quat_y_q;
	assign quat_z       = quat_z_q;
	assign branch_taken = branch_q;
	assign degenerate   = degen_q;

endmodule
`default_nettype wire

// ----- sv/rmq_front.sv -----
`default_nettype none
module rmq_front
	import rmq_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int AW         = DATA_WIDTH + 3
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [DATA_WIDTH-1:0]  m00,
	input  wire logic signed [DATA_WIDTH-1:0]  m01,
	input  wire logic signed [DATA_WIDTH-1:0]  m02,
	input  wire logic signed [DATA_WIDTH-1:0]  m10,
	input  wire logic signed [DATA_WIDTH-1:0]  m11,
	input  wire logic signed [DATA_WIDTH-1:0]  m12,
	input  wire logic signed [DATA_WIDTH-1:0]  m20,
	input  wire logic signed [DATA_WIDTH-1:0]  m21,
	input  wire logic signed [DATA_WIDTH-1:0]  m22,
	output branch_t                            branch_s1,
	output logic                               degen_s1,
	output logic [AW-2:0]                      arg_s1,
	output logic [LANES-1:0]                   neg_s1,
	output logic [LANES-1:0][DATA_WIDTH:0]     mag_s1
);

	localparam int DW = DATA_WIDTH;
	localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;

	logic signed [AW-1:0] e00, e11, e22, trace, arg;
	logic signed [DW:0]   s01, s02, s10, s12, s20, s21;
	logic signed [DW:0]   n [LANES];
	branch_t              br;
	logic                 degen;

	assign e00 = AW'(m00);
	assign e11 = AW'(m11);
	assign e22 = AW'(m22);
	assign s01 = (DW+1)'(m01);
	assign s02 = (DW+1)'(m02);
	assign s10 = (DW+1)'(m10);
	assign s12 = (DW+1)'(m12);
	assign s20 = (DW+1)'(m20);
	assign s21 = (DW+1)'(m21);
	assign trace = e00 + e11 + e22;

	always_comb begin
		priority if (trace > 0) begin
			br = BR_TRACE;
		end else if (m22 > ((m11 > m00) ? m11 : m00)) begin
			br = BR_Z;
		end else if (m11 > m00) begin
			br = BR_Y;
		end else begin
			br = BR_X;
		end
		unique case (br)
			BR_TRACE: begin
				arg  = trace + ONE;
				n[0] = '0;
				n[1] = s21 - s12;
				n[2] = s10 - s01;
				n[3] = s02 - s20;
			end
			BR_X: begin
				arg  = e00 - e11 - e22 + ONE;
				n[0] = s12 - s21;
				n[1] = '0;
				n[2] = s01 + s10;
				n[3] = s02 + s20;
			end
			BR_Y: begin
				arg  = e11 - e22 - e00 + ONE;
				n[0] = s20 - s02;
				n[1] = s10 + s01;
				n[2] = '0;
				n[3] = s12 + s21;
			end
			default: begin
				arg  = e22 - e00 - e11 + ONE;
				n[0] = s01 - s10;
				n[1] = s20 + s02;
				n[2] = s21 + s12;
				n[3] = '0;
			end
		endcase
		degen = (arg <= 0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			branch_s1 <= br;
			degen_s1  <= degen;
			arg_s1    <= degen ? '0 : arg[AW-2:0];
			for (int l = 0; l < LANES; l++) begin
				neg_s1[l] <= n[l][DW];
				mag_s1[l] <= n[l][DW] ? (DW+1)'(-n[l]) : (DW+1)'(n[l]);
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/rmq_sqrt_cell.sv -----
`default_nettype none
module rmq_sqrt_cell #(
	parameter int RW = 16,
	parameter int SW = 8
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [2*RW-1:0] rad_i,
	input  wire logic [RW:0]     rem_i,
	input  wire logic [RW-1:0]   root_i,
	input  wire logic [SW-1:0]   side_i,
	output logic      [2*RW-1:0] rad_o,
	output logic      [RW:0]     rem_o,
	output logic      [RW-1:0]   root_o,
	output logic      [SW-1:0]   side_o
);

	logic [RW+2:0] cand, sub, nr;
	logic          ge;

	assign cand = {rem_i, rad_i[2*RW-1 -: 2]};
	assign sub  = {1'b0, root_i, 2'b01};
	assign ge   = (cand >= sub);
	assign nr   = ge ? (cand - sub) : cand;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o  <= rad_i << 2;
			rem_o  <= nr[RW:0];
			root_o <= {root_i[RW-2:0], ge};
			side_o <= side_i;
		end
	end

endmodule
`default_nettype wire

// ----- sv/rmq_div_cell.sv -----
`default_nettype none
module rmq_div_cell
	import rmq_pkg::*;
#(
	parameter int RW  = 16,
	parameter int NMW = 32,
	parameter int SW  = 7
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [RW-1:0]               h_i,
	input  wire logic [LANES-1:0][NMW-1:0]   dvd_i,
	input  wire logic [LANES-1:0][RW-1:0]    rem_i,
	input  wire logic [LANES-1:0][NMW-1:0]   quo_i,
	input  wire logic [SW-1:0]               side_i,
	output logic      [RW-1:0]               h_o,
	output logic      [LANES-1:0][NMW-1:0]   dvd_o,
	output logic      [LANES-1:0][RW-1:0]    rem_o,
	output logic      [LANES-1:0][NMW-1:0]   quo_o,
	output logic      [SW-1:0]               side_o
);

	logic [RW:0] cand [LANES];
	logic [RW:0] nr   [LANES];
	logic        ge   [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			cand[l] = {rem_i[l], dvd_i[l][NMW-1]};
			ge[l]   = (cand[l] >= {1'b0, h_i});
			nr[l]   = ge[l] ? (cand[l] - {1'b0, h_i}) : cand[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_o    <= h_i;
			side_o <= side_i;
			for (int l = 0; l < LANES; l++) begin
				dvd_o[l] <= dvd_i[l] << 1;
				rem_o[l] <= nr[l][RW-1:0];
				quo_o[l] <= {quo_i[l][NMW-2:0], ge[l]};
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/rmq_checker.sv -----
`default_nettype none
module rmq_checker
	import rmq_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic signed [DATA_WIDTH-1:0] quat_w,
	input wire logic signed [DATA_WIDTH-1:0] quat_x,
	input wire logic signed [DATA_WIDTH-1:0] quat_y,
	input wire logic signed [DATA_WIDTH-1:0] quat_z,
	input wire logic [1:0]                   branch_taken,
	input wire logic                         degenerate
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_x)
			&& $stable(quat_y) && $stable(quat_z) && $stable(degenerate))
		else $error("output word changed while stalled");

	a_degen_branch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> branch_taken != BR_TRACE)
		else $error("degenerate flagged on trace path");

	a_degen_ident: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> quat_x == 0 && quat_y == 0 && quat_z == 0)
		else $error("degenerate word not identity");

	a_trace_w: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && branch_taken == BR_TRACE |-> quat_w >= 0)
		else $error("negative w on trace path");

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker #(
	.FRAC_BITS (FRAC_BITS),
	.DATA_WIDTH(DATA_WIDTH)
) u_rmq_checker (.*);
`default_nettype wire

// ----- verif/tb_rotation_matrix_to_quaternion_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_rotation_matrix_to_quaternion_core;
	import rmq_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int DW = DATA_WIDTH_DEF;

	typedef logic signed [DW-1:0] entry_t;
	typedef struct packed {
		entry_t  w, x, y, z;
		branch_t br;
		logic    degen;
	} quat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	entry_t m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0, m12 = '0;
	entry_t m20 = '0, m21 = '0, m22 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	entry_t quat_w, quat_x, quat_y, quat_z;
	branch_t branch_taken;
	logic degenerate;

	quat_t expected_quats[$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int degen_seen = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int branch_seen[4] = '{0, 0, 0, 0};

	rotation_matrix_to_quaternion_core DUT (
		.clk, .arst_n, .in_valid, .in_ready,
		.m00, .m01, .m02, .m10, .m11, .m12, .m20, .m21, .m22,
		.out_valid, .out_ready,
		.quat_w, .quat_x, .quat_y, .quat_z, .branch_taken, .degenerate
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint sat_entry(longint v);
		longint hi, lo;
		hi = (longint'(1) <<< (DW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic longint half_root(longint a);
		longint n, r, b;
		n = a <<< (FB - 2);
		r = 0;
		b = longint'(1) <<< 60;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint round_div(longint n, longint h);
		longint mag, q;
		mag = (n < 0) ? -n : n;
		q = ((mag <<< (FB - 2)) + (h >>> 1)) / h;
		if (q > (longint'(1) <<< DW)) q = longint'(1) <<< DW;
		return sat_entry((n < 0) ? -q : q);
	endfunction

	function automatic quat_t predict_quat(entry_t e[9]);
		longint m[3][3];
		longint q[3];
		longint w, a, h, one;
		int i, j, k;
		quat_t r;
		one = longint'(1) <<< FB;
		for (int t = 0; t < 9; t++) m[t / 3][t % 3] = e[t];
		a = m[0][0] + m[1][1] + m[2][2];
		r.degen = 1'b0;
		if (a > 0) begin
			r.br = BR_TRACE;
			h = half_root(a + one);
			w = sat_entry(h);
			q[0] = round_div(m[2][1] - m[1][2], h);
			q[1] = round_div(m[1][0] - m[0][1], h);
			q[2] = round_div(m[0][2] - m[2][0], h);
		end else begin
			i = 0;
			if (m[1][1] > m[0][0]) i = 1;
			if (m[2][2] > m[i][i]) i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			r.br = (i == 0) ? BR_X : (i == 1) ? BR_Y : BR_Z;
			a = m[i][i] - m[j][j] - m[k][k] + one;
			if (a <= 0) begin
				r.degen = 1'b1;
				w = sat_entry(one);
				q[0] = 0; q[1] = 0; q[2] = 0;
			end else begin
				h = half_root(a);
				q[i] = sat_entry(h);
				w = round_div(m[j][k] - m[k][j], h);
				q[j] = round_div(m[i][j] + m[j][i], h);
				q[k] = round_div(m[i][k] + m[k][i], h);
			end
		end
		r.w = entry_t'(w);
		r.x = entry_t'(q[0]);
		r.y = entry_t'(q[1]);
		r.z = entry_t'(q[2]);
		return r;
	endfunction

	task automatic send_matrix(entry_t e[9]);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} =
			{e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
		in_valid = 1'b1;
		expected_quats.push_back(predict_quat(e));
		do @(posedge clk); while (!in_ready);
		words_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_diag(int a, int b, int c, int off);
		entry_t e[9];
		for (int t = 0; t < 9; t++) e[t] = entry_t'(off + t * 37);
		e[0] = entry_t'(a); e[4] = entry_t'(b); e[8] = entry_t'(c);
		send_matrix(e);
	endtask

	task automatic send_random(int mode);
		entry_t e[9];
		for (int t = 0; t < 9; t++) begin
			case (mode)
			0: e[t] = entry_t'($urandom);
			1: e[t] = entry_t'($signed($urandom_range(32768)) - 16384);
			default: e[t] = entry_t'($urandom_range(1) ? 16'h7fff : 16'h8000);
			endcase
		end
		if (mode == 1 && $urandom_range(3) == 0) begin
			e[0] = entry_t'(-$signed($urandom_range(16384)));
			e[4] = entry_t'(-$signed($urandom_range(16384)));
			e[8] = entry_t'(-$signed($urandom_range(16384)));
		end
		send_matrix(e);
	endtask

	task automatic wait_drain();
		int guard;
		guard = 0;
		while (expected_quats.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (60) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		quat_t exp_q;
		if (arst_n && out_valid && out_ready) begin
			if (expected_quats.size() == 0) begin
				$error("word with no expectation pending");
				errors++;
			end else begin
				exp_q = expected_quats.pop_front();
				words_checked++;
				branch_seen[branch_taken]++;
				if (degenerate) degen_seen++;
				if (quat_w !== exp_q.w) begin
					$error("quat_w exp %0d got %0d", exp_q.w, quat_w); errors++;
				end
				if (quat_x !== exp_q.x) begin
					$error("quat_x exp %0d got %0d", exp_q.x, quat_x); errors++;
				end
				if (quat_y !== exp_q.y) begin
					$error("quat_y exp %0d got %0d", exp_q.y, quat_y); errors++;
				end
				if (quat_z !== exp_q.z) begin
					$error("quat_z exp %0d got %0d", exp_q.z, quat_z); errors++;
				end
				if (branch_taken !== exp_q.br) begin
					$error("branch_taken exp %0d got %0d", exp_q.br, branch_taken); errors++;
				end
				if (degenerate !== exp_q.degen) begin
					$error("degenerate exp %0d got %0d", exp_q.degen, degenerate); errors++;
				end
			end
		end
	end

	task automatic test_directed();
		entry_t e[9];
		send_diag(16384, 16384, 16384, 0);
		send_diag(32767, 32767, 32767, 100);
		send_diag(-16384, -16384, 16384, 0);
		send_diag(16384, -16384, -16384, 5);
		send_diag(-16384, 16384, -16384, 9);
		send_diag(0, 0, 0, 0);
		send_diag(-32768, -32768, -32768, 0);
		send_diag(-32768, 32767, 32767, 0);
		send_diag(32767, -32768, -32768, 1000);
		send_diag(-32768, -32768, 32767, -1000);
		send_diag(-100, -100, -100, 0);
		send_diag(1, 0, 0, 0);
		send_diag(0, -32768, 0, 0);
		send_diag(-5, -5, -5, 0);
		for (int t = 0; t < 9; t++) e[t] = 16'sh7fff;
		send_matrix(e);
		for (int t = 0; t < 9; t++) e[t] = 16'sh8000;
		send_matrix(e);
		for (int t = 0; t < 9; t++) e[t] = (t % 2) ? 16'sh8000 : 16'sh7fff;
		send_matrix(e);
		for (int t = 0; t < 9; t++) e[t] = (t % 2) ? 16'sh7fff : 16'sh8000;
		send_matrix(e);
		send_diag(-16383, -16384, -16384, 1);
		send_diag(-16384, -16384, -16384, -12000);
		wait_drain();
	endtask

	task automatic test_random(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int t = 0; t < n; t++) send_random($urandom_range(9) < 6 ? 1 : ($urandom_range(4) ? 0 : 2));
		wait_drain();
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		@(negedge clk);
		hold_cycles = 300;
		for (int t = 0; t < 100; t++) send_random(1);
		wait_drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_directed();
		test_random(170, 0, 0);
		test_random(150, 46, 0);
		test_random(150, 0, 46);
		test_random(150, 31, 31);
		test_backpressure();
		if (expected_quats.size() != 0) begin
			$error("%0d expected words never arrived", expected_quats.size());
			errors++;
		end
		$display("sent %0d matrices, checked %0d words; branches trace/x/y/z %0d/%0d/%0d/%0d",
			words_sent, words_checked, branch_seen[0], branch_seen[1], branch_seen[2],
			branch_seen[3]);
		$display("degenerate words %0d; idle, stall and long hold-off phases run",
			degen_seen);
		if (errors == 0) begin
			$display("rotation_matrix_to_quaternion_core test passed");
		end else begin
			$display("rotation_matrix_to_quaternion_core test failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("rotation_matrix_to_quaternion_core test failed");
		$finish;
	end
endmodule
`default_nettype wire
